// ===== sv/ede_pkg.sv =====
`timescale 1ns / 1ps
// ede_pkg: shared types and constants of the edit distance engine
// used by every module of the block but ede_ram; depends on nothing
package ede_pkg;

   localparam int CH_W   = 8;
   localparam int DIST_W = 7;

   typedef enum logic [1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_APPEND = 2'd1,
      KIND_QUERY  = 2'd2,
      KIND_END    = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [CH_W-1:0]   ch;
   } req_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              overflow;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_END_WB
   } state_type;

   typedef struct packed {
      logic clear_ref;
      logic append;
      logic restart;
      logic set_ovf;
      logic q_start;
      logic sweep_step;
      logic q_done;
      logic end_read;
      logic load_rsp;
   } ctl_cmd_type;

   typedef struct packed {
      logic ref_full;
      logic ref_empty;
      logic query_full;
      logic last_entry;
      logic rsp_free;
   } ctl_sts_type;

endpackage

// ===== sv/edit_distance_engine_unit.sv =====
`timescale 1ns / 1ps
// edit_distance_engine_unit: levenshtein distance of a streamed query against a stored reference
// depends on ede_pkg, ede_ctrl, ede_datapath and ede_ram
//
// req channel: one transaction carries kind and ch. clear empties the reference and the
// overflow flag, append stores a reference byte, query byte updates one dp row, end query
// returns one rsp transaction with the distance and the sticky overflow flag.
// clear, append, a dropped byte and a query byte with an empty reference complete in ST_IDLE.
// a query byte sweeps the row memory one row entry per cycle, read of the next entry
// overlapped with the write of the current one.
// end query reads the row memory, then loads the rsp register in ST_END_WB once it is free;
// rsp_valid rises the cycle after that load.
// rsp is held in an output register; a stalled receiver only blocks the next end query,
// which waits in ST_END_WB with req_ready low; transactions before it are still taken.
// reset clears lengths, overflow flag and rsp_valid; memories need no clearing,
// so req_ready is high as soon as reset is released.
// bytes beyond MAX_LEN are dropped and raise the overflow flag until the next clear.
module edit_distance_engine_unit #(
   parameter int MAX_LEN = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ede_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ede_pkg::rsp_type rsp_payload
);
   import ede_pkg::*;

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   ede_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind (req_payload.kind),
      .sts      (sts),
      .cmd      (cmd)
   );

   ede_datapath #(
      .MAX_LEN(MAX_LEN)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_payload.ch),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );
endmodule

// ===== sv/ede_ram.sv =====
`timescale 1ns / 1ps
// ede_ram: generic single write port, single read port ram with registered read
// no dependencies
module ede_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== sv/ede_ctrl.sv =====
`timescale 1ns / 1ps
// ede_ctrl: sequencer of the edit distance engine
// depends on ede_pkg; drives the datapath through ctl_cmd_type
module ede_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ede_pkg::kind_type    req_kind,
   input  ede_pkg::ctl_sts_type sts,
   output ede_pkg::ctl_cmd_type cmd
);
   import ede_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_kind)
                  KIND_CLEAR: begin
                     cmd.clear_ref = 1'b1;
                  end
                  KIND_APPEND: begin
                     cmd.restart = 1'b1;
                     if (sts.ref_full) begin
                        cmd.set_ovf = 1'b1;
                     end else begin
                        cmd.append = 1'b1;
                     end
                  end
                  KIND_QUERY: begin
                     if (sts.query_full) begin
                        cmd.set_ovf = 1'b1;
                     end else if (sts.ref_empty) begin
                        cmd.q_done = 1'b1;
                     end else begin
                        cmd.q_start = 1'b1;
                        state_in    = ST_SWEEP;
                     end
                  end
                  KIND_END: begin
                     cmd.end_read = 1'b1;
                     state_in     = ST_END_WB;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (sts.last_entry) begin
               cmd.q_done = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_END_WB: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               cmd.restart  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule

// ===== sv/ede_datapath.sv =====
`timescale 1ns / 1ps
// ede_datapath: reference and row memories, dp cell update, lengths and result register
// depends on ede_pkg and ede_ram
module ede_datapath #(
   parameter int MAX_LEN = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [ede_pkg::CH_W-1:0] req_ch,
   input  ede_pkg::ctl_cmd_type cmd,
   output ede_pkg::ctl_sts_type sts,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ede_pkg::rsp_type     rsp_payload
);
   import ede_pkg::*;

   localparam int LEN_W  = $clog2(MAX_LEN + 1);
   localparam int ADDR_W = $clog2(MAX_LEN);
   localparam int SUM_W  = LEN_W + 1;

   logic [LEN_W-1:0]  ref_len_ff, ref_len_in;
   logic [LEN_W-1:0]  ql_ff, ql_in;
   logic              ovf_ff, ovf_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [LEN_W-1:0]  diag_ff, diag_in;
   logic [LEN_W-1:0]  left_ff, left_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [CH_W-1:0]   ch_ff, ch_in;
   rsp_type           rsp_ff, rsp_in;

   logic [CH_W-1:0]   ref_rdata;
   logic [LEN_W-1:0]  dp_rdata;
   logic [ADDR_W-1:0] rd_addr;
   logic              rd_en;
   logic              query_empty;
   logic [LEN_W-1:0]  up;
   logic [SUM_W-1:0]  diag_sum, up_sum, left_sum, min_ab, min_abc;
   logic [LEN_W-1:0]  new_val;
   logic [LEN_W-1:0]  end_val;

   // previous row is the identity until the first byte of a query rewrites it
   assign query_empty = (ql_ff == '0);
   assign up          = query_empty ? (LEN_W'(idx_ff) + LEN_W'(1)) : dp_rdata;

   assign diag_sum = {1'b0, diag_ff} + SUM_W'(ref_rdata != ch_ff);
   assign up_sum   = {1'b0, up} + SUM_W'(1);
   assign left_sum = {1'b0, left_ff} + SUM_W'(1);
   assign min_ab   = (diag_sum < up_sum) ? diag_sum : up_sum;
   assign min_abc  = (min_ab < left_sum) ? min_ab : left_sum;
   assign new_val  = min_abc[LEN_W-1:0];

   assign end_val = sts.ref_empty ? ql_ff : (query_empty ? ref_len_ff : dp_rdata);

   assign rd_en = cmd.q_start | cmd.sweep_step | cmd.end_read;
   always_comb begin
      if (cmd.q_start) begin
         rd_addr = '0;
      end else if (cmd.sweep_step) begin
         rd_addr = idx_ff + ADDR_W'(1);
      end else begin
         rd_addr = ADDR_W'(ref_len_ff - LEN_W'(1));
      end
   end

   ede_ram #(
      .WIDTH(CH_W),
      .DEPTH(MAX_LEN)
   ) u_ref_ram (
      .clock  (clock),
      .wr_en  (cmd.append),
      .wr_addr(ref_len_ff[ADDR_W-1:0]),
      .wr_data(req_ch),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(ref_rdata)
   );

   ede_ram #(
      .WIDTH(LEN_W),
      .DEPTH(MAX_LEN)
   ) u_row_ram (
      .clock  (clock),
      .wr_en  (cmd.sweep_step),
      .wr_addr(idx_ff),
      .wr_data(new_val),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(dp_rdata)
   );

   always_comb begin
      ref_len_in   = ref_len_ff;
      ql_in        = ql_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      diag_in      = diag_ff;
      left_in      = left_ff;
      idx_in       = idx_ff;
      ch_in        = ch_ff;
      rsp_in       = rsp_ff;
      if (cmd.clear_ref) begin
         ref_len_in = '0;
         ovf_in     = 1'b0;
         ql_in      = '0;
      end
      if (cmd.append) begin
         ref_len_in = ref_len_ff + LEN_W'(1);
      end
      if (cmd.set_ovf) begin
         ovf_in = 1'b1;
      end
      if (cmd.restart) begin
         ql_in = '0;
      end
      if (cmd.q_start) begin
         idx_in  = '0;
         diag_in = ql_ff;
         left_in = ql_ff + LEN_W'(1);
         ch_in   = req_ch;
      end
      if (cmd.sweep_step) begin
         idx_in  = idx_ff + ADDR_W'(1);
         diag_in = up;
         left_in = new_val;
      end
      if (cmd.q_done) begin
         ql_in = ql_ff + LEN_W'(1);
      end
      if (cmd.load_rsp) begin
         rsp_valid_in    = 1'b1;
         rsp_in.distance = DIST_W'(end_val);
         rsp_in.overflow = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_len_ff   <= '0;
         ql_ff        <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ref_len_ff   <= ref_len_in;
         ql_ff        <= ql_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      diag_ff <= diag_in;
      left_ff <= left_in;
      idx_ff  <= idx_in;
      ch_ff   <= ch_in;
      rsp_ff  <= rsp_in;
   end

   assign sts.ref_full   = (ref_len_ff == LEN_W'(MAX_LEN));
   assign sts.ref_empty  = (ref_len_ff == '0);
   assign sts.query_full = (ql_ff == LEN_W'(MAX_LEN));
   assign sts.last_entry = ((LEN_W'(idx_ff) + LEN_W'(1)) == ref_len_ff);
   assign sts.rsp_free   = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_ref_len_bound: assert property (@(posedge clock) disable iff (reset)
      ref_len_ff <= LEN_W'(MAX_LEN))
      else $error("reference length beyond maximum");

   a_query_len_bound: assert property (@(posedge clock) disable iff (reset)
      ql_ff <= LEN_W'(MAX_LEN))
      else $error("query length beyond maximum");

   a_sweep_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.sweep_step |-> (LEN_W'(idx_ff) < ref_len_ff))
      else $error("row sweep past reference length");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> sts.rsp_free)
      else $error("result register overwritten");
endmodule
